[rtl/lags_pkg.sv]
package lags_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 64;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ADDR_W = ROW_W + 1;

   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int GEN_W     = 32;

   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int EXT_A_W   = (ROW_CNT_W > COL_CNT_W) ? ROW_CNT_W : COL_CNT_W;
   localparam int EXT_W     = (CSR_W > EXT_A_W) ? CSR_W : EXT_A_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 1'd1;
   localparam logic [CSR_W-1:0]     EXTENT_RESET = 7'd64;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_ADVANCE = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   localparam logic [3:0] BIRTH_COUNT  = 4'd3;
   localparam logic [3:0] SURVIVE_LOW  = 4'd2;
   localparam logic [3:0] SURVIVE_HIGH = 4'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] row;
      logic [5:0] column;
      logic       cell_in;
   } req_type;

   typedef struct packed {
      logic             cell_out;
      logic [GEN_W-1:0] generation_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_ADV_PRIME,
      ST_ADV_LOAD,
      ST_ADV_CELL,
      ST_ADV_STORE,
      ST_DONE
   } state_type;

endpackage

[rtl/life_automaton_grid_step.sv]
// Life (B3/S23) grid engine. Two banks of MAX_ROWS rows, each row one MAX_COLUMNS-bit word
// in a single-port-read, single-port-write memory; the active area is the top-left corner
// set by the rows/columns registers (0 acts as 1, values above the maximum saturate).
// After reset a clearing pass zeroes every word of both banks with req_stall held high.
// One item is in work at a time: a write or read goes through an access state and a done
// state to the result register, an unused action straight to the done state. In an advance
// one neighbor-count unit evaluates one cell per cycle from a three-row window, and each
// row costs one memory read and one write. Rows and columns outside the active area are
// copied unchanged; a finished result sits in an output register, and a new item is taken
// while it waits.
module life_automaton_grid_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lags_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lags_pkg::rsp_type             rsp_payload,
   input  logic                          csr_write,
   input  logic [lags_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lags_pkg::CSR_W-1:0]    csr_wdata
);
   import lags_pkg::*;

   state_type               state_ff, state_in;
   logic                    bank_ff, bank_in;
   logic [GEN_W-1:0]        gen_ff, gen_in;
   logic [CSR_W-1:0]        rows_cfg_ff, rows_cfg_in;
   logic [CSR_W-1:0]        cols_cfg_ff, cols_cfg_in;
   req_type                 item_ff, item_in;
   logic [ROW_W-1:0]        r_ff, r_in;
   logic [COL_W-1:0]        c_ff, c_in;
   logic [MAX_COLUMNS-1:0]  above_ff, above_in;
   logic [MAX_COLUMNS-1:0]  center_ff, center_in;
   logic [MAX_COLUMNS-1:0]  below_ff, below_in;
   logic [MAX_COLUMNS-1:0]  result_ff, result_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic                    cell_ff, cell_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [MAX_COLUMNS-1:0]  cell_mem [2**ADDR_W];
   logic [MAX_COLUMNS-1:0]  rd_data_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [ADDR_W-1:0]       mem_raddr;
   logic [MAX_COLUMNS-1:0]  mem_wdata;

   logic                    req_accept;
   logic [EXT_W-1:0]        rows_eff, cols_eff;
   logic                    item_inside;
   logic [ROW_W-1:0]        item_row;
   logic [COL_W-1:0]        item_col;
   logic                    row_active, last_row, last_col;
   logic                    above_ok, below_ok, left_ok, right_ok;
   logic [COL_W-1:0]        c_left, c_right;
   logic [3:0]              nb_count;
   logic                    alive, next_bit;
   logic                    rsp_load;

   function automatic logic [EXT_W-1:0] clamp_extent(logic [CSR_W-1:0] value,
                                                     logic [EXT_W-1:0] limit);
      logic [EXT_W-1:0] wide;
      wide = EXT_W'(value);
      if (value == '0) return EXT_W'(1);
      if (wide > limit) return limit;
      return wide;
   endfunction

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign rows_eff    = clamp_extent(rows_cfg_ff, EXT_W'(MAX_ROWS));
   assign cols_eff    = clamp_extent(cols_cfg_ff, EXT_W'(MAX_COLUMNS));
   assign item_inside = (EXT_W'(item_ff.row) < rows_eff) && (EXT_W'(item_ff.column) < cols_eff);
   assign item_row    = ROW_W'(item_ff.row);
   assign item_col    = COL_W'(item_ff.column);

   // neighborhood of cell (r, c) in the window; outside the active area reads dead
   assign row_active = EXT_W'(r_ff) < rows_eff;
   assign last_row   = (r_ff == ROW_W'(MAX_ROWS - 1));
   assign last_col   = (EXT_W'(c_ff) + EXT_W'(1)) >= cols_eff;
   assign above_ok   = (r_ff != '0);
   assign below_ok   = (EXT_W'(r_ff) + EXT_W'(1)) < rows_eff;
   assign left_ok    = (c_ff != '0);
   assign right_ok   = (EXT_W'(c_ff) + EXT_W'(1)) < cols_eff;
   assign c_left     = c_ff - COL_W'(1);
   assign c_right    = c_ff + COL_W'(1);
   assign alive      = center_ff[c_ff];

   assign nb_count = 4'(above_ok & left_ok & above_ff[c_left])
                   + 4'(above_ok & above_ff[c_ff])
                   + 4'(above_ok & right_ok & above_ff[c_right])
                   + 4'(left_ok & center_ff[c_left])
                   + 4'(right_ok & center_ff[c_right])
                   + 4'(below_ok & left_ok & below_ff[c_left])
                   + 4'(below_ok & below_ff[c_ff])
                   + 4'(below_ok & right_ok & below_ff[c_right]);

   assign next_bit = alive ? ((nb_count == SURVIVE_LOW) || (nb_count == SURVIVE_HIGH))
                           : (nb_count == BIRTH_COUNT);

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_payload.action) inside
                  ACT_WRITE, ACT_READ: state_in = ST_ACCESS;
                  ACT_ADVANCE:         state_in = ST_ADV_PRIME;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_ACCESS:    state_in = ST_DONE;
         ST_ADV_PRIME: state_in = ST_ADV_LOAD;
         ST_ADV_LOAD:  state_in = row_active ? ST_ADV_CELL : ST_ADV_STORE;
         ST_ADV_CELL: begin
            if (last_col) state_in = ST_ADV_STORE;
         end
         ST_ADV_STORE: state_in = last_row ? ST_DONE : ST_ADV_LOAD;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      bank_in      = bank_ff;
      gen_in       = gen_ff;
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      item_in      = item_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      above_in     = above_ff;
      center_in    = center_ff;
      below_in     = below_ff;
      result_in    = result_ff;
      clr_in       = clr_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = {bank_ff, r_ff};
      mem_wdata    = result_ff;
      mem_raddr    = {bank_ff, r_ff + ROW_W'(2)};

      if (csr_write) begin
         unique case (csr_index)
            CSR_ROWS:    rows_cfg_in = csr_wdata;
            CSR_COLUMNS: cols_cfg_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            item_in   = req_payload;
            cell_in   = 1'b0;
            mem_raddr = (req_payload.action == ACT_ADVANCE) ? {bank_ff, ROW_W'(0)}
                                                             : {bank_ff, ROW_W'(req_payload.row)};
         end
         ST_ACCESS: begin
            mem_waddr        = {bank_ff, item_row};
            mem_wdata        = rd_data_ff;
            mem_wdata[item_col] = item_ff.cell_in;
            mem_we           = (item_ff.action == ACT_WRITE) && item_inside;
            cell_in          = (item_ff.action == ACT_READ) && item_inside && rd_data_ff[item_col];
         end
         ST_ADV_PRIME: begin
            above_in  = '0;
            center_in = rd_data_ff;
            r_in      = '0;
            mem_raddr = {bank_ff, ROW_W'(1)};
         end
         ST_ADV_LOAD: begin
            below_in  = rd_data_ff;
            result_in = center_ff;
            c_in      = '0;
         end
         ST_ADV_CELL: begin
            result_in[c_ff] = next_bit;
            c_in            = c_ff + COL_W'(1);
         end
         ST_ADV_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = {~bank_ff, r_ff};
            mem_wdata = result_ff;
            above_in  = center_ff;
            center_in = below_ff;
            r_in      = r_ff + ROW_W'(1);
            if (last_row) begin
               bank_in = ~bank_ff;
               gen_in  = gen_ff + GEN_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in            = 1'b1;
               rsp_in.cell_out         = cell_ff;
               rsp_in.generation_count = gen_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= cell_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bank_ff      <= 1'b0;
         gen_ff       <= '0;
         rows_cfg_ff  <= EXTENT_RESET;
         cols_cfg_ff  <= EXTENT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bank_ff      <= bank_in;
         gen_ff       <= gen_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      above_ff  <= above_in;
      center_ff <= center_in;
      below_ff  <= below_in;
      result_ff <= result_in;
      cell_ff   <= cell_in;
      rsp_ff    <= rsp_in;
   end

   // new generation never lands in the bank being read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_STORE) |-> (mem_we && (mem_waddr[ADDR_W-1] != bank_ff)))
      else $error("advance writes the source bank");

   // bank swap and generation count move together
   assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> (gen_ff == $past(gen_ff) + GEN_W'(1)))
      else $error("bank swap without generation step");

   // cell sweep stays inside the active columns
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_CELL) |-> (row_active && (EXT_W'(c_ff) < cols_eff)))
      else $error("cell sweep outside active area");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && (rsp_ff == $past(rsp_ff))))
      else $error("pending result lost");

endmodule

[tb/tb_life_automaton_grid_step.sv]
module tb_life_automaton_grid_step;
   import lags_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 50;
   localparam int PHASES        = 9;
   localparam int PRESSURE_PHASE = 4;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_W-1:0]     csr_wdata   = '0;

   // grid model
   bit               life_cells [MAX_ROWS][MAX_COLUMNS];
   logic [CSR_W-1:0] rows_setting     = EXTENT_RESET;
   logic [CSR_W-1:0] cols_setting     = EXTENT_RESET;
   logic [GEN_W-1:0] generation_total = '0;
   rsp_type          expected_results[$];
   req_type          pending_items[$];
   rsp_type          want;

   int  writes_seen = 0, advances_seen = 0, reads_seen = 0, unused_seen = 0;
   int  settings_used = 0;
   int  mismatch_count = 0;
   int  results_seen = 0;
   int  cycle_count = 0;

   // sender / receiver pacing
   bit  sender_idles = 1'b0;
   bit  receiver_stalls = 1'b0;
   int  stall_pct = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   bit  hold_armed = 1'b0;
   bit  hold_taken = 1'b0;
   int  hold_left = 0;

   life_automaton_grid_step u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int active_span(logic [CSR_W-1:0] setting, int limit);
      if (setting == 0) return 1;
      if (setting > limit) return limit;
      return int'(setting);
   endfunction

   function automatic void advance_life();
      bit next_cells [MAX_ROWS][MAX_COLUMNS];
      int rows, cols, neighbors, nr, nc;
      rows = active_span(rows_setting, MAX_ROWS);
      cols = active_span(cols_setting, MAX_COLUMNS);
      next_cells = life_cells;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            neighbors = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if ((dr != 0 || dc != 0) && nr >= 0 && nr < rows && nc >= 0 && nc < cols)
                     neighbors += life_cells[nr][nc];
               end
            end
            if (life_cells[r][c])
               next_cells[r][c] = (neighbors == SURVIVE_LOW || neighbors == SURVIVE_HIGH);
            else
               next_cells[r][c] = (neighbors == BIRTH_COUNT);
         end
      end
      life_cells = next_cells;
      generation_total++;
   endfunction

   function automatic void life_step(req_type item);
      rsp_type outcome;
      int      rows, cols;
      bit      in_area;
      rows = active_span(rows_setting, MAX_ROWS);
      cols = active_span(cols_setting, MAX_COLUMNS);
      in_area = (int'(item.row) < rows) && (int'(item.column) < cols);
      outcome.cell_out = 1'b0;
      case (item.action)
         ACT_WRITE: begin
            if (in_area) life_cells[item.row][item.column] = item.cell_in;
            writes_seen++;
         end
         ACT_ADVANCE: begin
            advance_life();
            advances_seen++;
         end
         ACT_READ: begin
            if (in_area) outcome.cell_out = life_cells[item.row][item.column];
            reads_seen++;
         end
         default: unused_seen++;
      endcase
      outcome.generation_count = generation_total;
      expected_results.push_back(outcome);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want_val);
      mismatch_count++;
      $display("MISMATCH @%0t %s: got %0d, expected %0d", $time, what, got, want_val);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) life_step(req_payload);
         if (!req_valid || !req_stall) begin
            if (sender_idles && gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_items.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (hold_armed && !hold_taken) begin
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
         rsp_stall <= 1'b1;
      end else if (receiver_stalls) begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no item outstanding", rsp_payload.generation_count, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.cell_out !== want.cell_out)
               report_mismatch("cell_out", rsp_payload.cell_out, want.cell_out);
            if (rsp_payload.generation_count !== want.generation_count)
               report_mismatch("generation_count", rsp_payload.generation_count,
                               want.generation_count);
         end
         results_seen <= results_seen + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_extent(input logic [CSR_W-1:0] rows_val, input logic [CSR_W-1:0] cols_val);
      wait_idle();
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows_val;
      @(posedge clock);
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols_val;
      rows_setting = rows_val;
      @(posedge clock);
      csr_write <= 1'b0;
      cols_setting = cols_val;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic queue_item(input logic [1:0] action, input int row, input int column,
                             input bit cell_in);
      req_type item;
      item.action = action;
      item.row = 6'(row);
      item.column = 6'(column);
      item.cell_in = cell_in;
      pending_items.push_back(item);
   endtask

   // writes and reads land in a small window so patterns interact; a few go anywhere
   task automatic random_phase(input int count);
      int      rows, cols, span_r, span_c, base_r, base_c, pick;
      req_type item;
      rows = active_span(rows_setting, MAX_ROWS);
      cols = active_span(cols_setting, MAX_COLUMNS);
      span_r = (rows < 8) ? rows : 8;
      span_c = (cols < 8) ? cols : 8;
      base_r = $urandom_range(0, rows - span_r);
      base_c = $urandom_range(0, cols - span_c);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         item.row = 6'(base_r + $urandom_range(0, span_r - 1));
         item.column = 6'(base_c + $urandom_range(0, span_c - 1));
         item.cell_in = ($urandom_range(0, 9) < 6);
         if (pick < 40) begin
            item.action = ACT_WRITE;
         end else if (pick < 54) begin
            item.action = ACT_ADVANCE;
         end else if (pick < 94) begin
            item.action = ACT_READ;
         end else if (pick < 97) begin
            item.action = ACT_UNUSED;
         end else begin
            item.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            item.row = 6'($urandom_range(0, 63));
            item.column = 6'($urandom_range(0, 63));
         end
         if (item.action == ACT_ADVANCE || item.action == ACT_UNUSED) begin
            item.row = 6'($urandom_range(0, 63));
            item.column = 6'($urandom_range(0, 63));
            item.cell_in = 1'($urandom_range(0, 1));
         end
         pending_items.push_back(item);
      end
   endtask

   initial begin
      int phase_rows [PHASES] = '{64, 1, 127, 0, 6, 3, 64, 0, 0};
      int phase_cols [PHASES] = '{64, 1, 5, 9, 6, 64, 2, 0, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      stall_pct = 30;

      // full grid: corners, unused code, a blinker
      queue_item(ACT_READ, 0, 0, 1'b0);
      queue_item(ACT_WRITE, 0, 0, 1'b1);
      queue_item(ACT_WRITE, 63, 63, 1'b1);
      queue_item(ACT_READ, 63, 63, 1'b0);
      queue_item(ACT_UNUSED, 63, 0, 1'b1);
      queue_item(ACT_WRITE, 10, 10, 1'b1);
      queue_item(ACT_WRITE, 10, 11, 1'b1);
      queue_item(ACT_WRITE, 10, 12, 1'b1);
      queue_item(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
      queue_item(ACT_READ, 9, 11, 1'b0);
      queue_item(ACT_READ, 10, 10, 1'b0);
      queue_item(ACT_READ, 0, 0, 1'b0);
      queue_item(ACT_WRITE, 11, 11, 1'b0);
      queue_item(ACT_READ, 11, 11, 1'b0);

      // zero rows acts as one, columns saturate; outside writes ignored, reads give 0
      write_extent(7'd0, 7'd127);
      queue_item(ACT_WRITE, 0, 40, 1'b1);
      queue_item(ACT_WRITE, 5, 40, 1'b1);
      queue_item(ACT_READ, 10, 11, 1'b0);
      queue_item(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63), 1'b0);
      queue_item(ACT_READ, 0, 40, 1'b0);

      // hidden cells come back; plant live cells just outside a 3x3 area
      write_extent(7'd64, 7'd64);
      queue_item(ACT_READ, 10, 11, 1'b0);
      queue_item(ACT_WRITE, 0, 3, 1'b1);
      queue_item(ACT_WRITE, 1, 3, 1'b1);

      write_extent(7'd3, 7'd3);
      queue_item(ACT_WRITE, 0, 0, 1'b1);
      queue_item(ACT_WRITE, 0, 1, 1'b1);
      queue_item(ACT_WRITE, 1, 0, 1'b1);
      queue_item(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
      queue_item(ACT_READ, 1, 1, 1'b0);
      queue_item(ACT_READ, 0, 2, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         if (p >= PHASES - 2) begin
            phase_rows[p] = $urandom_range(0, 127);
            phase_cols[p] = $urandom_range(0, 127);
         end
         write_extent(7'(phase_rows[p]), 7'(phase_cols[p]));
         if (p == PRESSURE_PHASE) begin
            sender_idles = 1'b0;
            receiver_stalls = 1'b0;
            hold_armed = 1'b1;
            random_phase(20);
         end else begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            stall_pct = $urandom_range(10, 60);
            random_phase(13);
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", 0, expected_results.size());
      $display("Covered %0d items (%0d results checked): %0d writes, %0d advances, %0d reads, %0d unused codes",
               writes_seen + advances_seen + reads_seen + unused_seen, results_seen,
               writes_seen, advances_seen, reads_seen, unused_seen);
      $display("%0d grid sizes applied, generation %0d reached, one %0d-cycle receiver hold",
               settings_used, generation_total, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
